FILE: sv/rblt_pkg.sv
// ----------------------------------------------------------------------------
// rblt_pkg
// Shared types and constants for the random balancer with learning table.
// ----------------------------------------------------------------------------
`default_nettype none

package rblt_pkg;

  // Configuration register indexes
  localparam int CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] CFG_SERVER_ADDRESS  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_SERVER_COUNT    = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_FLOOD_PORT_CODE = 2'd2;

  // Configuration reset values (server address is 10.1.1.254)
  localparam logic [31:0] SERVER_ADDRESS_RST  = 32'h0A01_01FE;
  localparam logic [15:0] SERVER_COUNT_RST    = 16'd4;
  localparam logic [15:0] FLOOD_PORT_CODE_RST = 16'd65531;

  // Stream widths
  localparam int InTdataWidth  = 128;
  localparam int InTuserWidth  = 2;
  localparam int OutTdataWidth = 48;
  localparam int OutTuserWidth = 4;

  // One classified event handed from the front end to the back end
  typedef struct packed {
    logic        toward;        // destination is the virtual server
    logic [31:0] key;           // source on server path, destination on return
    logic [15:0] ingress_port;
    logic [31:0] pbuf_id;
    logic [15:0] rand_egress;   // scaled random port
  } rblt_job_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } rblt_state_e;

endpackage

`default_nettype wire

FILE: sv/rblt_ram.sv
// ----------------------------------------------------------------------------
// rblt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rblt_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/rblt_front.sv
// ----------------------------------------------------------------------------
// rblt_front
// Accept packet-in events, drop the ones that give no result, pick the
// lookup key and scale the random word into the server port range.
// ----------------------------------------------------------------------------
`default_nettype none

module rblt_front (
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  input  wire logic [rblt_pkg::InTdataWidth-1:0]   s_axis_tdata,
  input  wire logic [rblt_pkg::InTuserWidth-1:0]   s_axis_tuser,
  input  wire logic [31:0]                         server_address_i,
  input  wire logic [15:0]                         server_count_i,
  input  wire logic                                q_full_i,
  output      logic                                push_o,
  output      rblt_pkg::rblt_job_t                 job_o
);

  logic        registered;
  logic        packet_in;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] in_port;
  logic [31:0] buf_id;
  logic [15:0] rnd;
  logic [16:0] range;
  logic [32:0] scaled;

  // Unpack item fields
  assign registered = s_axis_tuser[0];
  assign packet_in  = s_axis_tuser[1];
  assign src_addr   = s_axis_tdata[31:0];
  assign dst_addr   = s_axis_tdata[63:32];
  assign in_port    = s_axis_tdata[79:64];
  assign buf_id     = s_axis_tdata[111:80];
  assign rnd        = s_axis_tdata[127:112];

  // Take an item whenever the queue has room
  assign s_axis_tready = !q_full_i;

  // Push only events that produce a result
  assign push_o = s_axis_tvalid && !q_full_i && registered && packet_in;

  // Scale random word: (rnd * (count + 1)) >> 16
  assign range  = {1'b0, server_count_i} + 17'd1;
  assign scaled = {17'd0, rnd} * {16'd0, range};

  // Classify and build the job
  always_comb begin
    job_o.toward       = (dst_addr == server_address_i);
    job_o.key          = job_o.toward ? src_addr : dst_addr;
    job_o.ingress_port = in_port;
    job_o.pbuf_id      = buf_id;
    job_o.rand_egress  = scaled[31:16];
  end

endmodule

`default_nettype wire

FILE: sv/rblt_queue.sv
// ----------------------------------------------------------------------------
// rblt_queue
// Two-entry job queue between the front end and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rblt_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire rblt_pkg::rblt_job_t job_i,
  output      logic                full_o,
  input  wire logic                pop_i,
  output      logic                empty_o,
  output      rblt_pkg::rblt_job_t job_o
);

  rblt_pkg::rblt_job_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign job_o   = entry_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store job payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rblt_back.sv
// ----------------------------------------------------------------------------
// rblt_back
// Table engine: walk the learned entries through the table read port,
// learn new client addresses, resolve the return port and drive results.
// ----------------------------------------------------------------------------
`default_nettype none

module rblt_back #(
  parameter int TableDepth = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 q_empty_i,
  input  wire rblt_pkg::rblt_job_t                  job_i,
  output      logic                                 pop_o,
  input  wire logic [15:0]                          flood_port_code_i,
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output      logic [rblt_pkg::OutTdataWidth-1:0]   m_axis_tdata,
  output      logic [rblt_pkg::OutTuserWidth-1:0]   m_axis_tuser
);

  localparam int AddrWidth = $clog2(TableDepth);
  localparam logic [AddrWidth:0] DepthCount = (AddrWidth+1)'(TableDepth);

  rblt_pkg::rblt_state_e state_q, state_d;
  rblt_pkg::rblt_job_t   job_q;

  logic [AddrWidth:0] idx_q, idx_d;
  logic [AddrWidth:0] cnt_q, cnt_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [15:0]        res_egress_q, res_egress_d;
  logic               res_hit_q, res_hit_d;
  logic               res_learned_q, res_learned_d;
  logic               res_full_q, res_full_d;
  logic               out_vld_q, out_vld_d;
  logic [rblt_pkg::OutTdataWidth-1:0] out_data_q;
  logic [rblt_pkg::OutTuserWidth-1:0] out_user_q;

  logic        issue;
  logic        match;
  logic        miss;
  logic        tbl_full;
  logic        tbl_we;
  logic        out_free;
  logic        load_out;
  logic [31:0] addr_rdata;
  logic [15:0] port_rdata;

  // Table stores, read at the walk index and written at the fill count
  rblt_ram #(.Width(32), .Depth(TableDepth)) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (cnt_q[AddrWidth-1:0]),
    .wdata_i (job_q.key),
    .raddr_i (idx_q[AddrWidth-1:0]),
    .rdata_o (addr_rdata)
  );

  rblt_ram #(.Width(16), .Depth(TableDepth)) u_port_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (cnt_q[AddrWidth-1:0]),
    .wdata_i (job_q.ingress_port),
    .raddr_i (idx_q[AddrWidth-1:0]),
    .rdata_o (port_rdata)
  );

  // Control decode
  always_comb begin
    out_free = !out_vld_q || m_axis_tready;
    issue    = (state_q == rblt_pkg::ST_SCAN) && (idx_q < cnt_q);
    match    = (state_q == rblt_pkg::ST_SCAN) && cmp_vld_q && (addr_rdata == job_q.key);
    miss     = (state_q == rblt_pkg::ST_SCAN) && !issue && !cmp_vld_q;
    tbl_full = (cnt_q == DepthCount);
    tbl_we   = miss && job_q.toward && !tbl_full;
    pop_o    = (state_q == rblt_pkg::ST_IDLE) && !q_empty_i;
    load_out = (state_q == rblt_pkg::ST_FINISH) && out_free;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rblt_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = rblt_pkg::ST_SCAN;
        end
      end
      rblt_pkg::ST_SCAN: begin
        if (match || miss) begin
          state_d = rblt_pkg::ST_FINISH;
        end
      end
      rblt_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = rblt_pkg::ST_IDLE;
        end
      end
      default: state_d = rblt_pkg::ST_IDLE;
    endcase
  end

  // Walk, learn and result updates
  always_comb begin
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    cmp_vld_d     = issue && !match;
    res_egress_d  = res_egress_q;
    res_hit_d     = res_hit_q;
    res_learned_d = res_learned_q;
    res_full_d    = res_full_q;
    out_vld_d     = out_vld_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (issue) begin
      idx_d = idx_q + 1'b1;
    end
    if (tbl_we) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (match) begin
      res_hit_d     = !job_q.toward;
      res_egress_d  = job_q.toward ? job_q.rand_egress : port_rdata;
      res_learned_d = 1'b0;
      res_full_d    = 1'b0;
    end else if (miss) begin
      res_hit_d     = 1'b0;
      res_egress_d  = job_q.toward ? job_q.rand_egress : flood_port_code_i;
      res_learned_d = job_q.toward && !tbl_full;
      res_full_d    = job_q.toward && tbl_full;
    end
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rblt_pkg::ST_IDLE;
      idx_q     <= '0;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_egress_q  <= res_egress_d;
    res_hit_q     <= res_hit_d;
    res_learned_q <= res_learned_d;
    res_full_q    <= res_full_d;
    if (pop_o) begin
      job_q <= job_i;
    end
    if (load_out) begin
      out_data_q <= {job_q.pbuf_id, res_egress_q};
      out_user_q <= {res_full_q, res_learned_q, res_hit_q, job_q.toward};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

FILE: sv/random_balancer_with_learning_table_core.sv
// From input accept, an item passes the queue, the pop in the idle state, the walk over
// the learned entries through the single read port of the table RAMs (at most
// TableDepth) and the result register. The engine takes no new item before the last
// result is loaded; a two-entry queue lets input items be taken while the table walk is busy.
// Reset: control and configuration registers to defaults, table empty through a zero
// fill count; no clearing pass over the RAMs.
// ----------------------------------------------------------------------------
// random_balancer_with_learning_table_core
// Packet-in load balancer: random server port pick, client learning table and
// return path lookup with flood on miss.
// ----------------------------------------------------------------------------
`default_nettype none

module random_balancer_with_learning_table_core #(
  parameter int TableDepth = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // Configuration write port
  input  wire logic                                   cfg_we_i,
  input  wire logic [rblt_pkg::CfgIndexWidth-1:0]     cfg_index_i,
  input  wire logic [31:0]                            cfg_data_i,
  // Input stream
  input  wire logic                                   s_axis_tvalid,
  output      logic                                   s_axis_tready,
  // source_address, destination_address, ingress_port, packet_buffer_id, random_word
  input  wire logic [rblt_pkg::InTdataWidth-1:0]      s_axis_tdata,
  // from_registered, is_packet_in
  input  wire logic [rblt_pkg::InTuserWidth-1:0]      s_axis_tuser,
  // Result stream
  output      logic                                   m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // egress_port, echo_buffer_id
  output      logic [rblt_pkg::OutTdataWidth-1:0]     m_axis_tdata,
  // toward_server, lookup_hit, learned_new, table_full
  output      logic [rblt_pkg::OutTuserWidth-1:0]     m_axis_tuser
);

  logic [31:0] server_address_q;
  logic [15:0] server_count_q;
  logic [15:0] flood_port_code_q;

  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  rblt_pkg::rblt_job_t front_job;
  rblt_pkg::rblt_job_t queue_job;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_address_q  <= rblt_pkg::SERVER_ADDRESS_RST;
      server_count_q    <= rblt_pkg::SERVER_COUNT_RST;
      flood_port_code_q <= rblt_pkg::FLOOD_PORT_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rblt_pkg::CFG_SERVER_ADDRESS:  server_address_q  <= cfg_data_i;
        rblt_pkg::CFG_SERVER_COUNT:    server_count_q    <= cfg_data_i[15:0];
        rblt_pkg::CFG_FLOOD_PORT_CODE: flood_port_code_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  rblt_front u_front (
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .server_address_i (server_address_q),
    .server_count_i   (server_count_q),
    .q_full_i         (q_full),
    .push_o           (q_push),
    .job_o            (front_job)
  );

  rblt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (queue_job)
  );

  rblt_back #(.TableDepth(TableDepth)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .job_i             (queue_job),
    .pop_o             (q_pop),
    .flood_port_code_i (flood_port_code_q),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser)
  );

endmodule

`default_nettype wire

FILE: sv/rblt_checker.sv
// ----------------------------------------------------------------------------
// rblt_checker
// Port-level checks on the result stream of the balancer core.
// ----------------------------------------------------------------------------
`default_nettype none

module rblt_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [rblt_pkg::OutTdataWidth-1:0]  m_axis_tdata,
  input wire logic [rblt_pkg::OutTuserWidth-1:0]  m_axis_tuser
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
      $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed or dropped while stalled");

  // Server path never reports a lookup hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
    else $error("lookup hit on server path");

  // Return path never learns or reports a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tuser[2] && !m_axis_tuser[3])
    else $error("learn flags on return path");

  // Learned and dropped insert exclude each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[2] && m_axis_tuser[3]))
    else $error("learned and table full both set");

  // No result right after reset is released
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid out of reset");

endmodule

bind random_balancer_with_learning_table_core rblt_checker u_rblt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: dv/random_balancer_with_learning_table_core_test.sv
// ----------------------------------------------------------------------------
// random_balancer_with_learning_table_core_test
// Drives packet-in events into the balancer core and checks every result
// against a built-in prediction of the server pick, client learning and
// return path lookup, under random idling, a long output stall and several
// register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module random_balancer_with_learning_table_core_test;

  localparam int TableDepth   = 64;
  localparam int PoolSize     = 80;
  localparam int SettleCycles = 80;
  localparam int LongHold     = 300;
  localparam int QuietLimit   = 4000;

  // Unused register index, writes to it are dropped
  localparam logic [rblt_pkg::CfgIndexWidth-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    bit        registered;
    bit        packet_in;
    bit [31:0] src;
    bit [31:0] dst;
    bit [15:0] port;
    bit [31:0] pbuf_id;
    bit [15:0] rnd;
  } packet_event_t;

  typedef struct packed {
    bit [15:0] egress;
    bit [31:0] pbuf_id;
    bit        toward;
    bit        hit;
    bit        learned;
    bit        full;
  } route_result_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we_i = 1'b0;
  logic [rblt_pkg::CfgIndexWidth-1:0]  cfg_index_i = '0;
  logic [31:0]                         cfg_data_i = '0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  // source_address, destination_address, ingress_port, packet_buffer_id, random_word
  logic [rblt_pkg::InTdataWidth-1:0]   s_axis_tdata = '0;
  // from_registered, is_packet_in
  logic [rblt_pkg::InTuserWidth-1:0]   s_axis_tuser = '0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  // egress_port, echo_buffer_id
  logic [rblt_pkg::OutTdataWidth-1:0]  m_axis_tdata;
  // toward_server, lookup_hit, learned_new, table_full
  logic [rblt_pkg::OutTuserWidth-1:0]  m_axis_tuser;

  random_balancer_with_learning_table_core #(
    .TableDepth(TableDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // Predicted balancer state
  bit [31:0] server_address_q = rblt_pkg::SERVER_ADDRESS_RST;
  bit [15:0] server_count_q   = rblt_pkg::SERVER_COUNT_RST;
  bit [15:0] flood_code_q     = rblt_pkg::FLOOD_PORT_CODE_RST;
  bit [31:0] client_addr_q [TableDepth];
  bit [15:0] client_port_q [TableDepth];
  bit        slot_valid_q  [TableDepth];
  int        entry_count_q = 0;

  route_result_t expected_routes[$];
  bit [31:0]     client_pool[PoolSize];
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  bit            calm_q = 1'b0;
  bit            long_hold_req = 1'b0;

  // Return the slot holding addr, or -1
  function automatic int find_client(bit [31:0] addr);
    for (int i = 0; i < TableDepth; i++) begin
      if (slot_valid_q[i] && client_addr_q[i] == addr) return i;
    end
    return -1;
  endfunction

  // Predict the route for one event and update the learning table
  function automatic bit balance_event(packet_event_t ev, output route_result_t res);
    bit [47:0] scaled;
    int        slot;
    res = '0;
    res.pbuf_id = ev.pbuf_id;
    if (!(ev.registered && ev.packet_in)) return 1'b0;
    if (ev.dst == server_address_q) begin
      res.toward = 1'b1;
      scaled = 48'(ev.rnd) * (48'(server_count_q) + 48'd1);
      res.egress = scaled[31:16];
      if (find_client(ev.src) < 0) begin
        slot = -1;
        for (int i = 0; i < TableDepth; i++) begin
          if (!slot_valid_q[i]) begin
            slot = i;
            break;
          end
        end
        if (slot < 0) begin
          res.full = 1'b1;
        end else begin
          client_addr_q[slot] = ev.src;
          client_port_q[slot] = ev.port;
          slot_valid_q[slot] = 1'b1;
          entry_count_q++;
          res.learned = 1'b1;
        end
      end
    end else begin
      slot = find_client(ev.dst);
      if (slot >= 0) begin
        res.egress = client_port_q[slot];
        res.hit = 1'b1;
      end else begin
        res.egress = flood_code_q;
      end
    end
    return 1'b1;
  endfunction

  function automatic packet_event_t make_event(bit reg_sw, bit pkt_in, bit [31:0] src,
                                               bit [31:0] dst, bit [15:0] port,
                                               bit [31:0] pbuf_id, bit [15:0] rnd);
    packet_event_t ev;
    ev.registered = reg_sw;
    ev.packet_in  = pkt_in;
    ev.src        = src;
    ev.dst        = dst;
    ev.port       = port;
    ev.pbuf_id    = pbuf_id;
    ev.rnd        = rnd;
    return ev;
  endfunction

  // Offer one item, wait for the handshake, record its expected route
  task automatic send_event(packet_event_t ev);
    route_result_t res;
    @(negedge clk_i);
    if (!calm_q && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ev.rnd, ev.pbuf_id, ev.port, ev.dst, ev.src};
    s_axis_tuser  <= {ev.packet_in, ev.registered};
    do @(posedge clk_i); while (!s_axis_tready);
    if (balance_event(ev, res)) expected_routes.push_back(res);
  endtask

  // Drop valid, drain all results, then let any silent item finish
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(logic [rblt_pkg::CfgIndexWidth-1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      rblt_pkg::CFG_SERVER_ADDRESS:  server_address_q = value;
      rblt_pkg::CFG_SERVER_COUNT:    server_count_q   = value[15:0];
      rblt_pkg::CFG_FLOOD_PORT_CODE: flood_code_q     = value[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(bit [31:0] addr, bit [15:0] count, bit [15:0] flood);
    settle();
    write_register(rblt_pkg::CFG_SERVER_ADDRESS, addr);
    write_register(rblt_pkg::CFG_SERVER_COUNT, {16'd0, count});
    write_register(rblt_pkg::CFG_FLOOD_PORT_CODE, {16'd0, flood});
  endtask

  // Build one random event: noise, client-to-server or return path
  function automatic packet_event_t random_event(int span);
    packet_event_t ev;
    int            pick;
    ev = make_event(1'b1, 1'b1, $urandom, $urandom, 16'($urandom), $urandom, 16'($urandom));
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       ev.rnd = 16'h0000;
      1:       ev.rnd = 16'hFFFF;
      default: ;
    endcase
    if (pick < 8) begin
      {ev.packet_in, ev.registered} = 2'($urandom_range(0, 2));
    end else if (pick < 52) begin
      ev.dst = server_address_q;
      if ($urandom_range(0, 9) != 0) ev.src = client_pool[$urandom_range(0, span - 1)];
    end else if ($urandom_range(0, 9) < 7) begin
      ev.dst = client_pool[$urandom_range(0, span - 1)];
    end
    return ev;
  endfunction

  // Messages that are dropped without a result
  task automatic test_ignored_events();
    send_event(make_event(1'b0, 1'b1, 32'hC0A8_0101, server_address_q, 16'd3,
                          32'h1111_0000, 16'h4000));
    send_event(make_event(1'b1, 1'b0, 32'hC0A8_0102, server_address_q, 16'd4,
                          32'h1111_0001, 16'h4000));
    send_event(make_event(1'b0, 1'b0, 32'hC0A8_0103, 32'hC0A8_0101, 16'd5,
                          32'h1111_0002, 16'h4000));
  endtask

  // Learn clients, repeat a known source, then hit and miss on return
  task automatic test_learn_and_lookup();
    send_event(make_event(1'b1, 1'b1, 32'hC0A8_0001, server_address_q, 16'd7,
                          32'h0000_0000, 16'h0000));
    send_event(make_event(1'b1, 1'b1, 32'hC0A8_0001, server_address_q, 16'd9,
                          32'hFFFF_FFFF, 16'hFFFF));
    send_event(make_event(1'b1, 1'b1, 32'h0000_0000, server_address_q, 16'hFFFF,
                          32'h8000_0001, 16'h8000));
    send_event(make_event(1'b1, 1'b1, 32'hFFFF_FFFF, server_address_q, 16'h0000,
                          32'h7FFF_FFFE, 16'h7FFF));
    send_event(make_event(1'b1, 1'b1, 32'h0A00_0005, 32'hC0A8_0001, 16'd1,
                          32'h2222_0000, 16'h1234));
    send_event(make_event(1'b1, 1'b1, 32'h0A00_0005, 32'h0000_0000, 16'd2,
                          32'h2222_0001, 16'h1234));
    send_event(make_event(1'b1, 1'b1, 32'h0A00_0005, 32'hFFFF_FFFF, 16'd2,
                          32'h2222_0002, 16'h1234));
    send_event(make_event(1'b1, 1'b1, 32'h0A00_0005, 32'hC0A8_00FF, 16'd2,
                          32'h2222_0003, 16'h1234));
  endtask

  // Register extremes, zero server count and an unused index
  task automatic test_config_extremes();
    settle();
    write_register(rblt_pkg::CFG_SERVER_COUNT, 32'd0);
    send_event(make_event(1'b1, 1'b1, 32'hC0A8_0001, server_address_q, 16'd7,
                          32'h3333_0000, 16'hFFFF));
    settle();
    write_register(rblt_pkg::CFG_SERVER_COUNT, 32'd65279);
    send_event(make_event(1'b1, 1'b1, 32'hC0A8_0001, server_address_q, 16'd7,
                          32'h3333_0001, 16'hFFFF));
    send_event(make_event(1'b1, 1'b1, 32'hC0A8_0001, server_address_q, 16'd7,
                          32'h3333_0002, 16'h0001));
    settle();
    write_register(rblt_pkg::CFG_SERVER_COUNT, 32'd1);
    write_register(rblt_pkg::CFG_FLOOD_PORT_CODE, 32'd0);
    send_event(make_event(1'b1, 1'b1, 32'hC0A8_0001, server_address_q, 16'd7,
                          32'h3333_0003, 16'h8000));
    send_event(make_event(1'b1, 1'b1, 32'h0A00_0005, 32'hC0A8_0077, 16'd7,
                          32'h3333_0004, 16'h0000));
    settle();
    write_register(rblt_pkg::CFG_FLOOD_PORT_CODE, 32'h0000_FFFF);
    write_register(rblt_pkg::CFG_SERVER_ADDRESS, 32'h0000_0000);
    send_event(make_event(1'b1, 1'b1, 32'h0A00_0005, 32'hC0A8_0077, 16'd7,
                          32'h3333_0005, 16'h0000));
    send_event(make_event(1'b1, 1'b1, 32'hC0A8_0001, 32'h0000_0000, 16'd7,
                          32'h3333_0006, 16'hC000));
    settle();
    write_register(rblt_pkg::CFG_SERVER_ADDRESS, 32'hFFFF_FFFF);
    write_register(CFG_UNUSED, 32'h0000_0000);
    send_event(make_event(1'b1, 1'b1, 32'hC0A8_0001, 32'hFFFF_FFFF, 16'd7,
                          32'h3333_0007, 16'hC000));
    send_event(make_event(1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 16'd7,
                          32'h3333_0008, 16'hC000));
  endtask

  // Hold the result side for a long stretch while items keep coming
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    repeat (12) send_event(random_event(24));
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (long_hold_req) @(posedge clk_i);
  endtask

  task automatic test_random_traffic(int count, int span, int calm_from);
    for (int i = 0; i < count; i++) begin
      if (i >= calm_from) calm_q = 1'b1;
      send_event(random_event(span));
    end
  endtask

  // Fill the table with fresh sources, then overflow it
  task automatic test_table_full();
    bit [31:0] fresh;
    while (entry_count_q < TableDepth + 4) begin
      do fresh = $urandom; while (find_client(fresh) >= 0 || fresh == server_address_q);
      if (entry_count_q >= TableDepth) entry_count_q++;
      send_event(make_event(1'b1, 1'b1, fresh, server_address_q, 16'($urandom),
                            $urandom, 16'($urandom)));
    end
    entry_count_q = TableDepth;
    send_event(make_event(1'b1, 1'b1, client_addr_q[5], server_address_q, 16'd1,
                          $urandom, 16'($urandom)));
    send_event(make_event(1'b1, 1'b1, 32'h0A00_0005, client_addr_q[TableDepth - 1],
                          16'd1, $urandom, 16'($urandom)));
  endtask

  // Result side: random stall bursts and the long hold
  initial begin : result_sink
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (!calm_q && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expected route
  always @(posedge clk_i) begin : route_checker
    route_result_t got;
    route_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.egress    = m_axis_tdata[15:0];
      got.pbuf_id   = m_axis_tdata[47:16];
      got.toward    = m_axis_tuser[0];
      got.hit       = m_axis_tuser[1];
      got.learned   = m_axis_tuser[2];
      got.full      = m_axis_tuser[3];
      if (expected_routes.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: egress %0d buffer %h flags %b", got.egress,
                   got.pbuf_id, {got.full, got.learned, got.hit, got.toward});
        mismatch_count++;
      end else begin
        want = expected_routes.pop_front();
        if (got.egress != want.egress || got.pbuf_id != want.pbuf_id ||
            got.toward != want.toward || got.hit != want.hit ||
            got.learned != want.learned || got.full != want.full) begin
          if (mismatch_count < 10)
            $display("mismatch: egress %0d/%0d buffer %h/%h flags %b/%b (exp/act)",
                     want.egress, got.egress, want.pbuf_id, got.pbuf_id,
                     {want.full, want.learned, want.hit, want.toward},
                     {got.full, got.learned, got.hit, got.toward});
          mismatch_count++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main_sequence
    foreach (client_pool[i]) client_pool[i] = $urandom;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_ignored_events();
    test_learn_and_lookup();
    test_config_extremes();

    configure(rblt_pkg::SERVER_ADDRESS_RST, rblt_pkg::SERVER_COUNT_RST,
              rblt_pkg::FLOOD_PORT_CODE_RST);
    test_random_traffic(620, 24, 620);
    test_backpressure();

    configure($urandom, 16'($urandom_range(1, 65279)), 16'($urandom));
    test_random_traffic(620, 48, 620);
    test_table_full();

    configure(rblt_pkg::SERVER_ADDRESS_RST, 16'($urandom_range(1, 8)),
              rblt_pkg::FLOOD_PORT_CODE_RST);
    test_random_traffic(620, PoolSize, 470);

    settle();
    mismatch_count += expected_routes.size();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
